/* src/nbse_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package nbse_pkg;
	localparam int MAX_BOXES = 8;
	localparam int IDX_BITS = $clog2(MAX_BOXES);
	localparam int CNT_BITS = 4;
	localparam int COORD_BITS = 32;
	localparam int FRACTION_BITS = 16;
	localparam int DIFF_BITS = COORD_BITS + 1;
	localparam int MAG_BITS = COORD_BITS + 1;
	localparam int T_BITS = FRACTION_BITS + 3;
	localparam logic signed [T_BITS-1:0] T_ONE = T_BITS'(1) <<< FRACTION_BITS;
	localparam logic signed [T_BITS-1:0] T_SAT = T_BITS'(2) <<< FRACTION_BITS;
	localparam int STEP_BITS = $clog2(FRACTION_BITS + 1);

	typedef enum logic {
		REQ_LOAD  = 1'b0,
		REQ_QUERY = 1'b1
	} req_type_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BOX,
		ST_AXIS,
		ST_DIV,
		ST_CLIP,
		ST_NEXT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [0:0] req_type;
		logic [2:0] entry_index;
		logic signed [31:0] coord_a_x;
		logic signed [31:0] coord_a_y;
		logic signed [31:0] coord_a_z;
		logic signed [31:0] coord_b_x;
		logic signed [31:0] coord_b_y;
		logic signed [31:0] coord_b_z;
	} req_t;

	typedef struct packed {
		logic hit;
		logic [2:0] hit_index;
		logic [16:0] cross_frac;
	} rsp_t;
endpackage
`default_nettype wire

/* src/nbse_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface nbse_req_if;
	logic valid;
	logic ready;
	nbse_pkg::req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface nbse_rsp_if;
	logic valid;
	logic ready;
	nbse_pkg::rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* src/nearest_box_segment_entry_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Content
// req       in         load of a box entry or segment query
// rsp       out        hit flag, box index and entry fraction (queries only)
// cfg       in         boxes_in_use write
// A load writes the box table when it is accepted. A query visits each box in use
// in turn and uses the single shared restoring divider (one quotient bit per cycle).
// The request side is not ready while a query runs or while its result waits in the
// output register. Reset clears control state and the count.
module nearest_box_segment_entry_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	nbse_req_if.sink req,
	nbse_rsp_if.source rsp,
	input  wire logic cfg_we,
	input  wire logic [nbse_pkg::CNT_BITS-1:0] cfg_wdata
);
	import nbse_pkg::*;

	logic signed [COORD_BITS-1:0] lo_q [3][MAX_BOXES];
	logic signed [COORD_BITS-1:0] hi_q [3][MAX_BOXES];
	logic [CNT_BITS-1:0] boxes_in_use_q;
	state_t state_q, state_d;
	logic signed [COORD_BITS-1:0] a_q [3];
	logic signed [COORD_BITS-1:0] b_q [3];
	logic [IDX_BITS:0] box_q;
	logic [1:0] axis_q;
	logic bound_q;
	logic signed [T_BITS-1:0] tmin_q, tmax_q, t1_q;
	logic found_q;
	logic [IDX_BITS-1:0] best_k_q;
	logic signed [T_BITS-1:0] best_t_q;
	logic [MAG_BITS:0] rem_q;
	logic [MAG_BITS-1:0] den_q;
	logic [FRACTION_BITS+1:0] mag_q;
	logic neg_q;
	logic [STEP_BITS-1:0] step_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic [CNT_BITS-1:0] n_lim;
	logic [IDX_BITS-1:0] k;
	logic signed [COORD_BITS-1:0] ca, cb, clo, chi;
	logic signed [DIFF_BITS-1:0] dd, nn;
	logic [MAG_BITS-1:0] an, ad;
	logic a_in_box, axis_in;
	logic [MAG_BITS:0] rem_sh;
	logic signed [T_BITS-1:0] tq, tl, th, nmin, nmax;
	logic accept;

	assign n_lim = (boxes_in_use_q > CNT_BITS'(MAX_BOXES)) ? CNT_BITS'(MAX_BOXES)
		: boxes_in_use_q;
	assign k = box_q[IDX_BITS-1:0];
	assign ca = a_q[axis_q];
	assign cb = b_q[axis_q];
	assign clo = lo_q[axis_q][k];
	assign chi = hi_q[axis_q][k];
	assign dd = DIFF_BITS'(cb) - DIFF_BITS'(ca);
	assign nn = (bound_q ? DIFF_BITS'(chi) : DIFF_BITS'(clo)) - DIFF_BITS'(ca);
	assign an = nn[DIFF_BITS-1] ? MAG_BITS'(-nn) : MAG_BITS'(nn);
	assign ad = dd[DIFF_BITS-1] ? MAG_BITS'(-dd) : MAG_BITS'(dd);
	assign axis_in = (ca >= clo) && (ca <= chi);
	always_comb begin
		a_in_box = 1'b1;
		for (int i = 0; i < 3; i++) begin
			if (a_q[i] < lo_q[i][k] || a_q[i] > hi_q[i][k]) begin
				a_in_box = 1'b0;
			end
		end
	end
	assign rem_sh = {rem_q[MAG_BITS-1:0], 1'b0};
	always_comb begin
		if (neg_q) begin
			tq = -$signed({1'b0, mag_q}) - ((rem_q != '0) ? T_BITS'(1) : T_BITS'(0));
			if (tq < -T_SAT) begin
				tq = -T_SAT;
			end
		end else begin
			tq = $signed({1'b0, mag_q});
		end
		tl = (t1_q > tq) ? tq : t1_q;
		th = (t1_q > tq) ? t1_q : tq;
		nmin = (tl > tmin_q) ? tl : tmin_q;
		nmax = (th < tmax_q) ? th : tmax_q;
	end

	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE) && !rsp_valid_q;
	assign rsp.valid = rsp_valid_q;
	assign rsp.payload = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boxes_in_use_q <= '0;
		end else if (cfg_we) begin
			boxes_in_use_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req.payload.req_type == REQ_LOAD
			&& 32'(req.payload.entry_index) < MAX_BOXES) begin
			if (req.payload.coord_a_x < req.payload.coord_b_x) begin
				lo_q[0][IDX_BITS'(req.payload.entry_index)] <= req.payload.coord_a_x;
				hi_q[0][IDX_BITS'(req.payload.entry_index)] <= req.payload.coord_b_x;
			end else begin
				lo_q[0][IDX_BITS'(req.payload.entry_index)] <= req.payload.coord_b_x;
				hi_q[0][IDX_BITS'(req.payload.entry_index)] <= req.payload.coord_a_x;
			end
			if (req.payload.coord_a_y < req.payload.coord_b_y) begin
				lo_q[1][IDX_BITS'(req.payload.entry_index)] <= req.payload.coord_a_y;
				hi_q[1][IDX_BITS'(req.payload.entry_index)] <= req.payload.coord_b_y;
			end else begin
				lo_q[1][IDX_BITS'(req.payload.entry_index)] <= req.payload.coord_b_y;
				hi_q[1][IDX_BITS'(req.payload.entry_index)] <= req.payload.coord_a_y;
			end
			if (req.payload.coord_a_z < req.payload.coord_b_z) begin
				lo_q[2][IDX_BITS'(req.payload.entry_index)] <= req.payload.coord_a_z;
				hi_q[2][IDX_BITS'(req.payload.entry_index)] <= req.payload.coord_b_z;
			end else begin
				lo_q[2][IDX_BITS'(req.payload.entry_index)] <= req.payload.coord_b_z;
				hi_q[2][IDX_BITS'(req.payload.entry_index)] <= req.payload.coord_a_z;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && req.payload.req_type == REQ_QUERY) begin
					state_d = ST_BOX;
				end
			end
			ST_BOX: begin
				if (CNT_BITS'(box_q) >= n_lim) begin
					state_d = ST_DONE;
				end else if (a_in_box) begin
					state_d = ST_NEXT;
				end else begin
					state_d = ST_AXIS;
				end
			end
			ST_AXIS: begin
				if (dd == '0) begin
					if (!axis_in) begin
						state_d = ST_NEXT;
					end else if (axis_q == 2'd2) begin
						state_d = ST_NEXT;
					end
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (step_q == '0) begin
					state_d = ST_CLIP;
				end
			end
			ST_CLIP: begin
				if (!bound_q) begin
					state_d = ST_AXIS;
				end else if (nmin > nmax || axis_q == 2'd2) begin
					state_d = ST_NEXT;
				end else begin
					state_d = ST_AXIS;
				end
			end
			ST_NEXT: state_d = ST_BOX;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath: the box verdict is settled in ST_NEXT through box_ok_q.
	logic box_ok_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			found_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && req.payload.req_type == REQ_QUERY) begin
						found_q <= 1'b0;
					end
				end
				ST_NEXT: begin
					if (box_ok_q && (!found_q || tmin_q < best_t_q)) begin
						found_q <= 1'b1;
					end
				end
				ST_DONE: rsp_valid_q <= 1'b1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				a_q[0] <= req.payload.coord_a_x;
				a_q[1] <= req.payload.coord_a_y;
				a_q[2] <= req.payload.coord_a_z;
				b_q[0] <= req.payload.coord_b_x;
				b_q[1] <= req.payload.coord_b_y;
				b_q[2] <= req.payload.coord_b_z;
				box_q <= '0;
			end
			ST_BOX: begin
				axis_q <= 2'd0;
				bound_q <= 1'b0;
				tmin_q <= '0;
				tmax_q <= T_ONE;
				box_ok_q <= a_in_box;
			end
			ST_AXIS: begin
				if (dd == '0) begin
					box_ok_q <= axis_in;
					axis_q <= axis_q + 2'd1;
				end else begin
					box_ok_q <= 1'b0;
					neg_q <= nn[DIFF_BITS-1] ^ dd[DIFF_BITS-1];
					den_q <= ad;
					step_q <= STEP_BITS'(FRACTION_BITS);
					if ({1'b0, an} >= {ad, 1'b0}) begin
						mag_q <= (FRACTION_BITS+2)'(T_SAT);
						rem_q <= '0;
						step_q <= '0;
					end else if (an >= ad) begin
						mag_q <= (FRACTION_BITS+2)'(1);
						rem_q <= (MAG_BITS+1)'(an - ad);
					end else begin
						mag_q <= '0;
						rem_q <= (MAG_BITS+1)'(an);
					end
				end
			end
			ST_DIV: begin
				if (step_q != '0) begin
					step_q <= step_q - STEP_BITS'(1);
					if (rem_sh >= {1'b0, den_q}) begin
						rem_q <= rem_sh - {1'b0, den_q};
						mag_q <= {mag_q[FRACTION_BITS:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						mag_q <= {mag_q[FRACTION_BITS:0], 1'b0};
					end
				end
			end
			ST_CLIP: begin
				if (!bound_q) begin
					t1_q <= tq;
					bound_q <= 1'b1;
				end else begin
					tmin_q <= nmin;
					tmax_q <= nmax;
					bound_q <= 1'b0;
					axis_q <= axis_q + 2'd1;
					box_ok_q <= !(nmin > nmax);
				end
			end
			ST_NEXT: begin
				if (box_ok_q && (!found_q || tmin_q < best_t_q)) begin
					best_k_q <= k;
					best_t_q <= tmin_q;
				end
				box_q <= box_q + (IDX_BITS+1)'(1);
			end
			ST_DONE: begin
				rsp_q.hit <= found_q;
				rsp_q.hit_index <= found_q ? 3'(best_k_q) : 3'd0;
				rsp_q.cross_frac <= found_q ? best_t_q[16:0] : 17'd0;
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire
